[src/esc_throttle_reverse_sequencer_macros.svh]
// Assertion macros used by the checker file of the ESC throttle sequencer.
// Each macro samples on the rising edge of i_clk and is disabled during reset.
`ifndef ESC_THROTTLE_REVERSE_SEQUENCER_MACROS_SVH
`define ESC_THROTTLE_REVERSE_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ets checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ETS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ets checker: next-cycle property failed");

`endif

[src/ets_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_pkg
// Types and constants of the ESC throttle sequencer with reverse brake.
// ---------------------------------------------------------------------------
package ets_pkg;

    // Command codes of an input transaction.
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Phase codes of a result.
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_BRAKE  = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNEL  = 2'd0;
    localparam logic [1:0] CFG_RANGE    = 2'd1;
    localparam logic [1:0] CFG_BRAKE    = 2'd2;
    localparam logic [1:0] CFG_REVERSAL = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [3:0]  RST_CHANNEL  = 4'd0;
    localparam logic [11:0] RST_RANGE    = 12'd1000;
    localparam logic [9:0]  RST_BRAKE    = 10'd200;
    localparam logic [9:0]  RST_REVERSAL = 10'd500;

    // Sequencer constants.
    localparam logic signed [15:0] NONZERO_MIN   = 16'sd33;
    localparam logic signed [15:0] LAST_NZ_RESET = 16'sd3277;
    localparam logic signed [15:0] THR_MINUS_ONE = -16'sd32768;
    localparam logic [9:0]         ELAPSED_MAX   = 10'd1023;

    // Pulse arithmetic in microseconds times 65536, 30 bits signed.
    localparam int                 PW_W        = 30;
    localparam logic signed [29:0] CENTER_SC   = 30'sd98304000;
    localparam logic signed [29:0] BRAKE_OFS   = -30'sd32768000;

    // Off count = floor(scaled / 320000) = floor((scaled >> 9) / 625).
    // The reciprocal of 625 at 2^28 is exact for a 19-bit dividend.
    localparam int          DIV_X_W   = 19;
    localparam int          DIV_SHIFT = 28;
    localparam logic [18:0] DIV_RECIP = 19'd429497;

    // One throttle command on its way to the pulse converter.
    typedef struct packed {
        logic [3:0]         channel;
        logic signed [15:0] throttle;
        logic signed [15:0] applied;
        logic [1:0]         phase;
    } t_item;

endpackage

[src/esc_throttle_reverse_sequencer.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while o_stall is low; a tick gives no result.
// A set-throttle result passes three registers: input, pulse clamp, reciprocal divide.
// Reset is synchronous, active low: state clears, registers return to their defaults.
// ---------------------------------------------------------------------------
// esc_throttle_reverse_sequencer
// Maps Q1.15 throttle commands to PWM off counts and runs the reverse
// brake sequence, counting millisecond ticks.
// ---------------------------------------------------------------------------
module esc_throttle_reverse_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [15:0] i_throttle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_out_channel,
    output logic [11:0]        o_off_count,
    output logic signed [15:0] o_applied_throttle,
    output logic [1:0]         o_phase
);
    import ets_pkg::*;

    logic [3:0]         r_channel;
    logic [11:0]        r_range;
    logic [9:0]         r_brake;
    logic [9:0]         r_reversal;
    logic               r_reversing;
    logic [9:0]         r_elapsed;
    logic signed [15:0] r_last_nz;
    logic               r_s0_valid;
    t_item              r_s0_item;

    logic               n_reversing;
    logic [9:0]         n_elapsed;
    logic signed [15:0] n_last_nz;
    logic [1:0]         n_phase;
    t_item              n_item;
    logic               accept;
    logic               s0_load;
    logic               pipe_ready;
    logic               last_pos;
    logic               rev_active;
    logic [9:0]         e_now;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel  <= RST_CHANNEL;
            r_range    <= RST_RANGE;
            r_brake    <= RST_BRAKE;
            r_reversal <= RST_REVERSAL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNEL:  r_channel  <= i_cfg_data[3:0];
                CFG_RANGE:    r_range    <= i_cfg_data;
                CFG_BRAKE:    r_brake    <= i_cfg_data[9:0];
                CFG_REVERSAL: r_reversal <= i_cfg_data[9:0];
                default:      r_channel  <= r_channel;
            endcase
        end
    end

    // Input handshake: the input register loads when empty or draining.
    assign s0_load = !r_s0_valid || pipe_ready;
    assign o_stall = !s0_load;
    assign accept  = i_valid && s0_load;

    // Reversal sequencing for one accepted transaction.
    always_comb begin
        last_pos    = !r_last_nz[15] && (r_last_nz != 16'sd0);
        rev_active  = (last_pos && i_throttle[15]) || r_reversing;
        e_now       = r_reversing ? r_elapsed : 10'd0;
        n_reversing = r_reversing;
        n_elapsed   = r_elapsed;
        n_last_nz   = r_last_nz;
        n_phase     = PH_NORMAL;
        if (accept) begin
            if (i_command == CMD_TICK) begin
                if (r_reversing && (r_elapsed != ELAPSED_MAX)) begin
                    n_elapsed = r_elapsed + 10'd1;
                end
            end else begin
                if (rev_active) begin
                    n_elapsed = e_now;
                    if (e_now >= r_reversal) begin
                        n_reversing = 1'b0;
                    end else begin
                        n_reversing = 1'b1;
                        n_phase     = (e_now <= r_brake) ? PH_BRAKE : PH_HOLD;
                    end
                end
                if ((n_phase == PH_NORMAL)
                    && ((i_throttle >= NONZERO_MIN) || (i_throttle <= -NONZERO_MIN))) begin
                    n_last_nz = i_throttle;
                end
            end
        end
        n_item.channel  = r_channel;
        n_item.throttle = i_throttle;
        n_item.phase    = n_phase;
        case (n_phase)
            PH_BRAKE: n_item.applied = THR_MINUS_ONE;
            PH_HOLD:  n_item.applied = 16'sd0;
            default:  n_item.applied = i_throttle;
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversing <= 1'b0;
            r_elapsed   <= 10'd0;
            r_last_nz   <= LAST_NZ_RESET;
        end else begin
            r_reversing <= n_reversing;
            r_elapsed   <= n_elapsed;
            r_last_nz   <= n_last_nz;
        end
    end

    // Input register: only set-throttle commands go on to the converter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_load) begin
            r_s0_valid <= accept && (i_command == CMD_SET);
        end
        if (accept && (i_command == CMD_SET)) begin
            r_s0_item <= n_item;
        end
    end

    ets_pulse_pipe u_pipe (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_range            (r_range),
        .i_valid            (r_s0_valid),
        .o_ready            (pipe_ready),
        .i_item             (r_s0_item),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_channel      (o_out_channel),
        .o_off_count        (o_off_count),
        .o_applied_throttle (o_applied_throttle),
        .o_phase            (o_phase)
    );

endmodule

[src/ets_pulse_pipe.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_pulse_pipe
// Two-stage pipeline that turns a throttle and phase into a clamped pulse
// width and then into a 12-bit PWM off count of a 20 ms period.
// ---------------------------------------------------------------------------
module ets_pulse_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [11:0]        i_range,
    input  logic               i_valid,
    output logic               o_ready,
    input  ets_pkg::t_item     i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_out_channel,
    output logic [11:0]        o_off_count,
    output logic signed [15:0] o_applied_throttle,
    output logic [1:0]         o_phase
);
    import ets_pkg::*;

    logic                      r_s1_valid;
    logic [DIV_X_W-1:0]        r_s1_x;
    t_item                     r_s1_item;
    logic                      r_o_valid;
    logic [11:0]               r_off;
    t_item                     r_o_item;

    logic                      s1_ready;
    logic                      o_ready_int;
    logic signed [PW_W-1:0]    prod;
    logic signed [PW_W-1:0]    half;
    logic signed [PW_W-1:0]    ofs;
    logic signed [PW_W-1:0]    ofs_clamped;
    logic signed [PW_W-1:0]    scaled;
    logic [DIV_X_W-1:0]        n_x;
    logic [2*DIV_X_W-1:0]      div_prod;

    // Stage handshakes: a stage loads when it is empty or its successor moves.
    assign s1_ready    = !r_o_valid || !i_stall;
    assign o_ready_int = !r_s1_valid || s1_ready;
    assign o_ready     = o_ready_int;

    // Pulse offset from center, clamped to plus or minus half the range.
    always_comb begin
        prod = PW_W'(i_item.throttle) * PW_W'($signed({1'b0, i_range}));
        half = $signed({3'b000, i_range, 15'b0});
        case (i_item.phase)
            PH_BRAKE: ofs = BRAKE_OFS;
            PH_HOLD:  ofs = '0;
            default:  ofs = prod;
        endcase
        if (ofs < -half) begin
            ofs_clamped = -half;
        end else if (ofs > half) begin
            ofs_clamped = half;
        end else begin
            ofs_clamped = ofs;
        end
        scaled = CENTER_SC + ofs_clamped;
        if (scaled <= 0) begin
            n_x = '0;
        end else begin
            n_x = scaled[27:9];
        end
    end

    // Division by 625 through the exact reciprocal.
    assign div_prod = r_s1_x * DIV_RECIP;

    // Stage one: clamped pulse width, pre-shifted by 512.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready_int) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready_int && i_valid) begin
            r_s1_x    <= n_x;
            r_s1_item <= i_item;
        end
    end

    // Stage two: result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_ready) begin
            r_o_valid <= r_s1_valid;
        end
        if (s1_ready && r_s1_valid) begin
            r_off    <= {2'b00, div_prod[DIV_SHIFT+9:DIV_SHIFT]};
            r_o_item <= r_s1_item;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_out_channel      = r_o_item.channel;
    assign o_off_count        = r_off;
    assign o_applied_throttle = r_o_item.applied;
    assign o_phase            = r_o_item.phase;

endmodule

[src/ets_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_checker
// Port-level checks of the ESC throttle sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "esc_throttle_reverse_sequencer_macros.svh"

module ets_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [11:0]        o_off_count,
    input  logic signed [15:0] o_applied_throttle,
    input  logic [1:0]         o_phase
);
    import ets_pkg::*;

    // A stalled result transaction stays offered with the same off count.
    `ETS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `ETS_ASSERT_NEXT(a_off_stable, o_valid && i_stall, $stable(o_off_count))

    // Brake applies full reverse, neutral hold applies zero.
    `ETS_ASSERT_NOW(a_brake_thr, o_valid && (o_phase == PH_BRAKE), o_applied_throttle == THR_MINUS_ONE)
    `ETS_ASSERT_NOW(a_hold_thr, o_valid && (o_phase == PH_HOLD), o_applied_throttle == 16'sd0)

    // The off count never exceeds 726, even with the largest pulse range.
    `ETS_ASSERT_NOW(a_off_bound, o_valid, o_off_count <= 12'd726)

endmodule

bind esc_throttle_reverse_sequencer ets_checker u_ets_checker (.*);
